### hw/rtl/tpdc_pkg.sv
`default_nettype none

package tpdc_pkg;

    localparam logic [7:0] TYPE_START = 8'h01;
    localparam logic [7:0] TYPE_DATA  = 8'h02;
    localparam logic [7:0] TYPE_MID   = 8'h03;
    localparam logic [7:0] TYPE_END   = 8'h04;

    localparam logic [15:0] HEADER_BYTES = 16'd8;
    localparam logic [15:0] MID_BYTES    = 16'd2;
    localparam logic [15:0] SUM_BYTES    = 16'd4;

    localparam logic [2:0] STATUS_RUNNING   = 3'd0;
    localparam logic [2:0] STATUS_COMPLETE  = 3'd1;
    localparam logic [2:0] STATUS_ERR_START = 3'd2;
    localparam logic [2:0] STATUS_ERR_TYPE  = 3'd3;
    localparam logic [2:0] STATUS_ERR_SUM   = 3'd4;

    typedef enum logic [2:0] {
        SP_WAIT,
        SP_STARTED,
        SP_COMPLETE,
        SP_ERR_START,
        SP_ERR_TYPE,
        SP_ERR_SUM
    } session_phase_t;

    typedef enum logic [2:0] {
        FP_TYPE,
        FP_HEADER,
        FP_LEN_HI,
        FP_LEN_LO,
        FP_PAYLOAD,
        FP_MID,
        FP_SUM
    } field_phase_t;

    typedef struct packed {
        logic       fwd_valid;
        logic [7:0] fwd_byte;
        logic       fwd_target;
        logic       ack_valid;
        logic [7:0] ack_byte;
        logic [2:0] status;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/typed_packet_deframer_checksum_core.sv
// A word accepted at the input is captured in an input register; the parser's result
// for it is held in an output register. Throughput: one word per cycle while out_ready
// does not stall the output register.
// Reset: rst_n clears all parser state, the running checksum and both valid flags;
// the session then returns to its waiting phase, where a START packet is accepted.
`default_nettype none

module typed_packet_deframer_checksum_core
    import tpdc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            fwd_valid,
    output logic [7:0]      fwd_byte,
    output logic            fwd_target,
    output logic            ack_valid,
    output logic [7:0]      ack_byte,
    output logic [2:0]      status
);

    logic       in_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    step_result;
    logic       out_free;
    logic       step_en;

    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    tpdc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (rx_byte_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rx_byte_reg <= rx_byte;
        end
        if (step_en)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fwd_valid  = result_reg.fwd_valid;
    assign fwd_byte   = result_reg.fwd_byte;
    assign fwd_target = result_reg.fwd_target;
    assign ack_valid  = result_reg.ack_valid;
    assign ack_byte   = result_reg.ack_byte;
    assign status     = result_reg.status;

endmodule

`default_nettype wire

### hw/rtl/tpdc_parser.sv
`default_nettype none

module tpdc_parser
    import tpdc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic [7:0] rx_byte,
    output result_t         result
);

    session_phase_t session_reg, session_next;
    field_phase_t   field_reg, field_next;
    logic [15:0]    count_reg, count_next;
    logic [15:0]    length_reg, length_next;
    logic [31:0]    run_sum_reg, run_sum_next;
    logic [31:0]    rx_sum_reg, rx_sum_next;
    logic           target_reg, target_next;

    logic [15:0]    count_inc;
    logic [31:0]    rx_sum_shift;
    logic           terminal;
    logic           fwd_hit;
    logic [7:0]     fwd_data;
    logic           ack_hit;
    logic [7:0]     ack_data;

    assign count_inc    = count_reg + 16'd1;
    assign rx_sum_shift = {rx_sum_reg[23:0], rx_byte};
    assign terminal     = (session_reg == SP_COMPLETE) || (session_reg == SP_ERR_START)
                       || (session_reg == SP_ERR_TYPE) || (session_reg == SP_ERR_SUM);

    always_comb
    begin
        session_next = session_reg;
        field_next   = field_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        run_sum_next = run_sum_reg;
        rx_sum_next  = rx_sum_reg;
        target_next  = target_reg;
        fwd_hit      = 1'b0;
        fwd_data     = 8'd0;
        ack_hit      = 1'b0;
        ack_data     = 8'd0;
        if (!terminal)
        begin
            unique case (field_reg)
                FP_TYPE:
                begin
                    count_next = 16'd0;
                    priority if (rx_byte == TYPE_START)
                    begin
                        if (session_reg != SP_WAIT)
                        begin
                            session_next = SP_ERR_START;
                        end
                        else
                        begin
                            field_next = FP_HEADER;
                        end
                    end
                    else if (rx_byte == TYPE_DATA)
                    begin
                        field_next = FP_LEN_HI;
                    end
                    else if (rx_byte == TYPE_MID)
                    begin
                        field_next = FP_MID;
                    end
                    else if (rx_byte == TYPE_END)
                    begin
                        rx_sum_next = 32'd0;
                        field_next  = FP_SUM;
                    end
                    else
                    begin
                        session_next = SP_ERR_TYPE;
                    end
                end
                FP_HEADER:
                begin
                    count_next = count_inc;
                    if (count_inc >= HEADER_BYTES)
                    begin
                        ack_hit      = 1'b1;
                        ack_data     = TYPE_START;
                        session_next = SP_STARTED;
                        field_next   = FP_TYPE;
                        count_next   = 16'd0;
                    end
                end
                FP_LEN_HI:
                begin
                    length_next = {rx_byte, 8'd0};
                    field_next  = FP_LEN_LO;
                end
                FP_LEN_LO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    count_next  = 16'd0;
                    field_next  = ({length_reg[15:8], rx_byte} == 16'd0) ? FP_TYPE : FP_PAYLOAD;
                end
                FP_PAYLOAD:
                begin
                    fwd_hit      = 1'b1;
                    fwd_data     = rx_byte;
                    run_sum_next = run_sum_reg + {24'd0, rx_byte};
                    count_next   = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        ack_hit    = 1'b1;
                        ack_data   = TYPE_DATA;
                        field_next = FP_TYPE;
                        count_next = 16'd0;
                    end
                end
                FP_MID:
                begin
                    count_next = count_inc;
                    if (count_inc >= MID_BYTES)
                    begin
                        target_next = 1'b1;
                        ack_hit     = 1'b1;
                        ack_data    = TYPE_MID;
                        field_next  = FP_TYPE;
                        count_next  = 16'd0;
                    end
                end
                FP_SUM:
                begin
                    rx_sum_next = rx_sum_shift;
                    count_next  = count_inc;
                    if (count_inc >= SUM_BYTES)
                    begin
                        field_next = FP_TYPE;
                        count_next = 16'd0;
                        if (rx_sum_shift == run_sum_reg)
                        begin
                            ack_hit      = 1'b1;
                            ack_data     = TYPE_END;
                            session_next = SP_COMPLETE;
                        end
                        else
                        begin
                            session_next = SP_ERR_SUM;
                        end
                    end
                end
                default:
                begin
                    field_next = FP_TYPE;
                    count_next = 16'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        result.fwd_valid  = fwd_hit;
        result.fwd_byte   = fwd_data;
        result.fwd_target = target_next;
        result.ack_valid  = ack_hit;
        result.ack_byte   = ack_data;
        unique case (session_next)
            SP_COMPLETE:  result.status = STATUS_COMPLETE;
            SP_ERR_START: result.status = STATUS_ERR_START;
            SP_ERR_TYPE:  result.status = STATUS_ERR_TYPE;
            SP_ERR_SUM:   result.status = STATUS_ERR_SUM;
            default:      result.status = STATUS_RUNNING;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= SP_WAIT;
            field_reg   <= FP_TYPE;
            count_reg   <= 16'd0;
            length_reg  <= 16'd0;
            run_sum_reg <= 32'd0;
            rx_sum_reg  <= 32'd0;
            target_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            session_reg <= session_next;
            field_reg   <= field_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            run_sum_reg <= run_sum_next;
            rx_sum_reg  <= rx_sum_next;
            target_reg  <= target_next;
        end
    end

endmodule

`default_nettype wire

### tb/tb_typed_packet_deframer_checksum_core.sv
`timescale 1ns / 100ps

module tb_typed_packet_deframer_checksum_core;

    import tpdc_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 10;

    class deframer_scoreboard;
        session_phase_t session;
        field_phase_t   field;
        logic [15:0]    count;
        logic [15:0]    length;
        logic [31:0]    byte_total;
        logic [31:0]    sent_check;
        logic           port_sel;
        result_t        expected_q[$];
        int unsigned    mismatches;
        int unsigned    checked;
        int unsigned    acks;

        function new();
            session    = SP_WAIT;
            field      = FP_TYPE;
            count      = '0;
            length     = '0;
            byte_total = '0;
            sent_check = '0;
            port_sel   = 1'b0;
            mismatches = 0;
            checked    = 0;
            acks       = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            result_t r;
            r = '0;
            if (session inside {SP_WAIT, SP_STARTED})
            begin
                case (field)
                    FP_TYPE:
                    begin
                        count = '0;
                        case (b)
                            TYPE_START:
                            begin
                                if (session != SP_WAIT)
                                    session = SP_ERR_START;
                                else
                                    field = FP_HEADER;
                            end
                            TYPE_DATA: field = FP_LEN_HI;
                            TYPE_MID:  field = FP_MID;
                            TYPE_END:
                            begin
                                sent_check = '0;
                                field = FP_SUM;
                            end
                            default: session = SP_ERR_TYPE;
                        endcase
                    end
                    FP_HEADER:
                    begin
                        count = count + 16'd1;
                        if (count >= HEADER_BYTES)
                        begin
                            r.ack_valid = 1'b1;
                            r.ack_byte = TYPE_START;
                            session = SP_STARTED;
                            field = FP_TYPE;
                            count = '0;
                        end
                    end
                    FP_LEN_HI:
                    begin
                        length = {b, 8'h00};
                        field = FP_LEN_LO;
                    end
                    FP_LEN_LO:
                    begin
                        length = length | {8'h00, b};
                        count = '0;
                        field = (length == 16'd0) ? FP_TYPE : FP_PAYLOAD;
                    end
                    FP_PAYLOAD:
                    begin
                        r.fwd_valid = 1'b1;
                        r.fwd_byte = b;
                        byte_total = byte_total + {24'h0, b};
                        count = count + 16'd1;
                        if (count >= length)
                        begin
                            r.ack_valid = 1'b1;
                            r.ack_byte = TYPE_DATA;
                            field = FP_TYPE;
                            count = '0;
                        end
                    end
                    FP_MID:
                    begin
                        count = count + 16'd1;
                        if (count >= MID_BYTES)
                        begin
                            port_sel = 1'b1;
                            r.ack_valid = 1'b1;
                            r.ack_byte = TYPE_MID;
                            field = FP_TYPE;
                            count = '0;
                        end
                    end
                    FP_SUM:
                    begin
                        sent_check = {sent_check[23:0], b};
                        count = count + 16'd1;
                        if (count >= SUM_BYTES)
                        begin
                            field = FP_TYPE;
                            count = '0;
                            if (sent_check == byte_total)
                            begin
                                r.ack_valid = 1'b1;
                                r.ack_byte = TYPE_END;
                                session = SP_COMPLETE;
                            end
                            else
                                session = SP_ERR_SUM;
                        end
                    end
                    default:
                    begin
                        field = FP_TYPE;
                        count = '0;
                    end
                endcase
            end
            r.fwd_target = port_sel;
            case (session)
                SP_COMPLETE:  r.status = STATUS_COMPLETE;
                SP_ERR_START: r.status = STATUS_ERR_START;
                SP_ERR_TYPE:  r.status = STATUS_ERR_TYPE;
                SP_ERR_SUM:   r.status = STATUS_ERR_SUM;
                default:      r.status = STATUS_RUNNING;
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result %h arrived with none expected", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.ack_valid === 1'b1)
                acks++;
            compare_field("fwd_valid", 32'(want.fwd_valid), 32'(got.fwd_valid));
            compare_field("fwd_byte", 32'(want.fwd_byte), 32'(got.fwd_byte));
            compare_field("fwd_target", 32'(want.fwd_target), 32'(got.fwd_target));
            compare_field("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
            compare_field("ack_byte", 32'(want.ack_byte), 32'(got.ack_byte));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       fwd_valid;
    logic [7:0] fwd_byte;
    logic       fwd_target;
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic [2:0] status;

    deframer_scoreboard sb;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        words_sent;
    int unsigned        stall_cycles;
    logic [31:0]        payload_total;
    string              ending_name;

    typed_packet_deframer_checksum_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .fwd_valid  (fwd_valid),
        .fwd_byte   (fwd_byte),
        .fwd_target (fwd_target),
        .ack_valid  (ack_valid),
        .ack_byte   (ack_byte),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        out_ready = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 77;
        words_sent = 0;
        stall_cycles = 0;
        payload_total = '0;
        sb = new();
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_byte(rx_byte);
        if (rst_n && out_valid && out_ready)
            sb.check_word({fwd_valid, fwd_byte, fwd_target, ack_valid, ack_byte, status});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_data(input int unsigned len, input int fill);
        logic [15:0] n;
        logic [7:0]  b;
        n = 16'(len);
        send_byte(TYPE_DATA);
        send_byte(n[15:8]);
        send_byte(n[7:0]);
        for (int unsigned i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            payload_total = payload_total + {24'h0, b};
            send_byte(b);
        end
    endtask

    task automatic send_mid();
        send_byte(TYPE_MID);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_end(input logic [31:0] check);
        send_byte(TYPE_END);
        send_byte(check[31:24]);
        send_byte(check[23:16]);
        send_byte(check[15:8]);
        send_byte(check[7:0]);
    endtask

    task automatic run_traffic(input int unsigned words);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_mid();
            else if (pick < 14)
                send_data(0, -1);
            else if (pick < 97)
                send_data($urandom_range(16, 1), -1);
            else
                send_data($urandom_range(300, 17), -1);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // DATA ahead of START must be taken as a normal packet.
        send_data(1, 8'hFF);
        send_data(0, -1);
        send_byte(TYPE_START);
        for (int i = 0; i < 8; i++)
            send_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
        send_data(2, 8'h00);
        send_mid();

        run_traffic(520);
        send_idle_pct = 77;
        recv_idle_pct = 24;
        run_traffic(520);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(520);

        case ($urandom_range(3))
            0:
            begin
                ending_name = "matching checksum";
                send_end(payload_total);
            end
            1:
            begin
                ending_name = "checksum mismatch";
                send_end(payload_total ^ (32'h1 << $urandom_range(31)));
            end
            2:
            begin
                ending_name = "second START";
                send_byte(TYPE_START);
            end
            default:
            begin
                ending_name = "unknown packet type";
                send_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, TYPE_END + 1)));
            end
        endcase
        // The session is closed now, so these words must all be ignored.
        repeat (12)
            send_byte(8'($urandom_range(255)));
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stream words, checked %0d results with %0d acks, across two",
                 words_sent, sb.checked, sb.acks);
        $display("stall mixes and a free-running stretch; session closed by %s (status %0d).",
                 ending_name, status);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
